@@ src/pipeline_execute_alu_branch_top_defines.svh @@
// assertion macros for the execute stage block
`ifndef PIPELINE_EXECUTE_ALU_BRANCH_TOP_DEFINES_SVH
`define PIPELINE_EXECUTE_ALU_BRANCH_TOP_DEFINES_SVH

// checked on clk_i, ignored while in reset
`define PEAB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on clk_i, also during reset
`define PEAB_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ src/peab_pkg.sv @@
package peab_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned OpW    = 4;
  localparam int unsigned RouteW = 2;
  localparam int unsigned CntW   = $clog2(DataW);

  typedef logic [DataW-1:0] word_t;

  typedef enum logic [OpW-1:0] {
    OP_NOP  = 4'd0,
    OP_ADD  = 4'd1,
    OP_SUB  = 4'd2,
    OP_MUL  = 4'd3,
    OP_DIV  = 4'd4,
    OP_ADDI = 4'd5,
    OP_LW   = 4'd6,
    OP_SW   = 4'd7,
    OP_BGEZ = 4'd8,
    OP_BLEZ = 4'd9,
    OP_BEQ  = 4'd10,
    OP_J    = 4'd11
  } op_e;

  typedef enum logic [RouteW-1:0] {
    ROUTE_CARRIED = 2'd0,
    ROUTE_FILE    = 2'd1,
    ROUTE_MEM_A   = 2'd2,
    ROUTE_MEM_B   = 2'd3
  } route_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MUL,
    ST_ABSA,
    ST_ABSB,
    ST_DIV,
    ST_FIX,
    ST_DONE
  } state_e;

  function automatic word_t pick_operand(route_e route, word_t carried, word_t file,
                                         word_t mem_a, word_t mem_b, logic late);
    word_t res;
    unique case (route)
      ROUTE_CARRIED: res = carried;
      ROUTE_FILE:    res = file;
      ROUTE_MEM_A:   res = late ? file : mem_a;
      ROUTE_MEM_B:   res = late ? file : mem_b;
      default:       res = carried;
    endcase
    return res;
  endfunction

endpackage

@@ src/pipeline_execute_alu_branch_top.sv @@
// Execute stage with operand forwarding: each instruction picks its two
// operands (carried, register file or a memory-stage result; a late stall
// sends memory routes to the register file), then runs through one shared
// 32-bit adder/subtractor under a small sequencer. ADD, SUB, ADDI, LW/SW
// address and branches are computed in ST_EXEC into the result register;
// MUL is shift-and-add at one bit a cycle; DIV is restoring division at
// one quotient bit a cycle plus sign fix-up (a zero divisor skips the loop
// and raises divide_fault). One instruction is in flight at a time; the
// next is taken as soon as the result sits in the output register, even
// while the far side stalls it.
module pipeline_execute_alu_branch_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [peab_pkg::OpW-1:0]            operation_i,
  input  logic signed [peab_pkg::DataW-1:0]   rs_carried_i,
  input  logic signed [peab_pkg::DataW-1:0]   rs_file_i,
  input  logic [peab_pkg::RouteW-1:0]         rs_route_i,
  input  logic signed [peab_pkg::DataW-1:0]   rt_carried_i,
  input  logic signed [peab_pkg::DataW-1:0]   rt_file_i,
  input  logic [peab_pkg::RouteW-1:0]         rt_route_i,
  input  logic signed [peab_pkg::DataW-1:0]   immediate_i,
  input  logic signed [peab_pkg::DataW-1:0]   mem_result_a_i,
  input  logic signed [peab_pkg::DataW-1:0]   mem_result_b_i,
  input  logic                                late_stall_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [peab_pkg::DataW-1:0]   dest_value_o,
  output logic                                dest_valid_o,
  output logic signed [peab_pkg::DataW-1:0]   mem_address_o,
  output logic                                branch_taken_o,
  output logic signed [peab_pkg::DataW-1:0]   saved_target_out_o,
  output logic                                divide_fault_o
);
  import peab_pkg::*;

  localparam logic [CntW-1:0] CntLast = CntW'(DataW - 1);

  state_e          state_q, state_d;
  op_e             op_q, op_d;
  word_t           a_q, a_d;
  word_t           b_q, b_d;
  word_t           imm_q, imm_d;
  word_t           acc_q, acc_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            neg_q, neg_d;

  word_t           res_dest_q, res_dest_d;
  logic            res_valid_q, res_valid_d;
  word_t           res_addr_q, res_addr_d;
  logic            res_taken_q, res_taken_d;
  logic            res_fault_q, res_fault_d;

  word_t           st_q, st_d;
  logic            out_valid_q;
  word_t           out_dest_q, out_addr_q, out_st_q;
  logic            out_dvalid_q, out_taken_q, out_fault_q;
  logic            out_load;

  // shared adder
  word_t           add_x, add_y;
  logic            add_sub;
  logic [DataW:0]  add_sum;
  word_t           sum;
  logic            carry;

  assign in_stall_o = (state_q != ST_IDLE);
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    add_x   = a_q;
    add_y   = b_q;
    add_sub = 1'b0;
    unique case (state_q)
      ST_EXEC: begin
        if (op_q == OP_ADDI || op_q == OP_LW || op_q == OP_SW) begin
          add_y = imm_q;
        end
        add_sub = (op_q == OP_SUB) || (op_q == OP_BEQ);
      end
      ST_MUL: begin
        add_x = acc_q;
        add_y = a_q;
      end
      ST_ABSA, ST_FIX: begin
        add_x   = '0;
        add_y   = a_q;
        add_sub = 1'b1;
      end
      ST_ABSB: begin
        add_x   = '0;
        add_y   = b_q;
        add_sub = 1'b1;
      end
      ST_DIV: begin
        add_x   = {acc_q[DataW-2:0], a_q[DataW-1]};
        add_y   = b_q;
        add_sub = 1'b1;
      end
      default: begin
        add_x = a_q;
      end
    endcase
    add_sum = {1'b0, add_x} + {1'b0, add_y ^ {DataW{add_sub}}} + {{DataW{1'b0}}, add_sub};
    sum     = add_sum[DataW-1:0];
    carry   = add_sum[DataW];
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_EXEC;
      ST_EXEC: begin
        if (op_q == OP_MUL) begin
          state_d = ST_MUL;
        end else if (op_q == OP_DIV && b_q != '0) begin
          state_d = ST_ABSA;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_MUL:  if (cnt_q == CntLast) state_d = ST_DONE;
      ST_ABSA: state_d = ST_ABSB;
      ST_ABSB: state_d = ST_DIV;
      ST_DIV:  if (cnt_q == CntLast) state_d = ST_FIX;
      ST_FIX:  state_d = ST_DONE;
      ST_DONE: if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    op_d        = op_q;
    a_d         = a_q;
    b_d         = b_q;
    imm_d       = imm_q;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    neg_d       = neg_q;
    res_dest_d  = res_dest_q;
    res_valid_d = res_valid_q;
    res_addr_d  = res_addr_q;
    res_taken_d = res_taken_q;
    res_fault_d = res_fault_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d  = op_e'(operation_i);
          a_d   = pick_operand(route_e'(rs_route_i), word_t'(rs_carried_i),
                               word_t'(rs_file_i), word_t'(mem_result_a_i),
                               word_t'(mem_result_b_i), late_stall_i);
          b_d   = pick_operand(route_e'(rt_route_i), word_t'(rt_carried_i),
                               word_t'(rt_file_i), word_t'(mem_result_a_i),
                               word_t'(mem_result_b_i), late_stall_i);
          imm_d = word_t'(immediate_i);
          acc_d = '0;
          cnt_d = '0;
        end
      end
      ST_EXEC: begin
        res_dest_d  = '0;
        res_valid_d = 1'b0;
        res_addr_d  = '0;
        res_taken_d = 1'b0;
        res_fault_d = 1'b0;
        unique case (op_q)
          OP_ADD, OP_SUB, OP_ADDI: begin
            res_dest_d  = sum;
            res_valid_d = 1'b1;
          end
          OP_LW, OP_SW: res_addr_d  = sum;
          OP_BGEZ:      res_taken_d = !a_q[DataW-1];
          OP_BLEZ:      res_taken_d = a_q[DataW-1] || (a_q == '0);
          OP_BEQ:       res_taken_d = (sum == '0);
          OP_J:         res_taken_d = 1'b1;
          OP_DIV: begin
            res_fault_d = (b_q == '0);
            neg_d       = a_q[DataW-1] ^ b_q[DataW-1];
          end
          default: begin
            res_valid_d = 1'b0;
          end
        endcase
      end
      ST_MUL: begin
        if (b_q[0]) acc_d = sum;
        a_d   = {a_q[DataW-2:0], 1'b0};
        b_d   = {1'b0, b_q[DataW-1:1]};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          res_dest_d  = b_q[0] ? sum : acc_q;
          res_valid_d = 1'b1;
        end
      end
      ST_ABSA: if (a_q[DataW-1]) a_d = sum;
      ST_ABSB: if (b_q[DataW-1]) b_d = sum;
      ST_DIV: begin
        if (carry) begin
          acc_d = sum;
        end else begin
          acc_d = add_x;
        end
        a_d   = {a_q[DataW-2:0], carry};
        cnt_d = cnt_q + 1'b1;
      end
      ST_FIX: begin
        res_dest_d  = neg_q ? sum : a_q;
        res_valid_d = 1'b1;
      end
      default: begin
        cnt_d = cnt_q;
      end
    endcase
  end

  assign st_d = (out_load && res_taken_q) ? imm_q : st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      st_q        <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      st_q    <= st_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    a_q         <= a_d;
    b_q         <= b_d;
    imm_q       <= imm_d;
    acc_q       <= acc_d;
    neg_q       <= neg_d;
    res_dest_q  <= res_dest_d;
    res_valid_q <= res_valid_d;
    res_addr_q  <= res_addr_d;
    res_taken_q <= res_taken_d;
    res_fault_q <= res_fault_d;
    if (out_load) begin
      out_dest_q   <= res_dest_q;
      out_dvalid_q <= res_valid_q;
      out_addr_q   <= res_addr_q;
      out_taken_q  <= res_taken_q;
      out_fault_q  <= res_fault_q;
      out_st_q     <= st_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign dest_value_o       = $signed(out_dest_q);
  assign dest_valid_o       = out_dvalid_q;
  assign mem_address_o      = $signed(out_addr_q);
  assign branch_taken_o     = out_taken_q;
  assign saved_target_out_o = $signed(out_st_q);
  assign divide_fault_o     = out_fault_q;

`include "pipeline_execute_alu_branch_top_defines.svh"

  `PEAB_ASSERT_RST(a_reset_idle, !rst_ni |-> (state_q == ST_IDLE) && !out_valid_q, "reset not idle")
  `PEAB_ASSERT(a_accept_exec, (in_valid_i && !in_stall_o) |=> (state_q == ST_EXEC), "accept lost")
  `PEAB_ASSERT(a_div_loop, (state_q == ST_DIV && cnt_q != CntLast) |=> (state_q == ST_DIV), "div loop cut short")
  `PEAB_ASSERT(a_fault_no_dest, (out_valid_o && divide_fault_o) |-> (!dest_valid_o && dest_value_o == 0), "fault with result")
  `PEAB_ASSERT(a_dest_no_branch, (out_valid_o && dest_valid_o) |-> (!branch_taken_o && mem_address_o == 0), "mixed result kinds")

endmodule

@@ tb/execute_checker.sv @@
`timescale 1ns / 1ps
module execute_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [peab_pkg::OpW-1:0]      operation_i,
  input  peab_pkg::word_t               rs_carried_i,
  input  peab_pkg::word_t               rs_file_i,
  input  logic [peab_pkg::RouteW-1:0]   rs_route_i,
  input  peab_pkg::word_t               rt_carried_i,
  input  peab_pkg::word_t               rt_file_i,
  input  logic [peab_pkg::RouteW-1:0]   rt_route_i,
  input  peab_pkg::word_t               immediate_i,
  input  peab_pkg::word_t               mem_result_a_i,
  input  peab_pkg::word_t               mem_result_b_i,
  input  logic                          late_stall_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  peab_pkg::word_t               dest_value_i,
  input  logic                          dest_valid_i,
  input  peab_pkg::word_t               mem_address_i,
  input  logic                          branch_taken_i,
  input  peab_pkg::word_t               saved_target_out_i,
  input  logic                          divide_fault_i,
  output int                            fail_count_o,
  output int                            pending_o
);
  import peab_pkg::*;

  typedef struct packed {
    word_t dest;
    logic  dest_ok;
    word_t addr;
    logic  taken;
    word_t target;
    logic  fault;
  } exec_res_t;

  exec_res_t result_q[$];
  word_t     branch_target;
  int        mismatches = 0;

  assign fail_count_o = mismatches;

  task automatic note_mismatch(input string what, input word_t got, input word_t want);
    $display("%0t execute_checker: %s got %h want %h", $time, what, got, want);
    mismatches++;
  endtask

  // late stall turns both memory routes into register-file reads
  function automatic word_t forward_src(logic [RouteW-1:0] route, word_t carried, word_t file,
                                        word_t mem_a, word_t mem_b, logic late);
    if (route == ROUTE_CARRIED) return carried;
    if (route == ROUTE_FILE || late) return file;
    return (route == ROUTE_MEM_A) ? mem_a : mem_b;
  endfunction

  function automatic exec_res_t execute_instr(logic [OpW-1:0] op, word_t rs, word_t rt,
                                              word_t imm, word_t target);
    exec_res_t r;
    word_t     mag_a;
    word_t     mag_b;
    word_t     quo;
    r = '0;
    case (op)
      OP_ADD: begin
        r.dest = rs + rt;
        r.dest_ok = 1'b1;
      end
      OP_SUB: begin
        r.dest = rs - rt;
        r.dest_ok = 1'b1;
      end
      OP_MUL: begin
        r.dest = rs * rt;
        r.dest_ok = 1'b1;
      end
      OP_DIV: begin
        if (rt == '0) begin
          r.fault = 1'b1;
        end else begin
          mag_a = rs[DataW-1] ? -rs : rs;
          mag_b = rt[DataW-1] ? -rt : rt;
          quo = mag_a / mag_b;
          r.dest = (rs[DataW-1] ^ rt[DataW-1]) ? -quo : quo;
          r.dest_ok = 1'b1;
        end
      end
      OP_ADDI: begin
        r.dest = rs + imm;
        r.dest_ok = 1'b1;
      end
      OP_LW, OP_SW: r.addr = rs + imm;
      OP_BGEZ: r.taken = !rs[DataW-1];
      OP_BLEZ: r.taken = rs[DataW-1] || (rs == '0);
      OP_BEQ: r.taken = (rs == rt);
      OP_J: r.taken = 1'b1;
      default: ;
    endcase
    r.target = r.taken ? imm : target;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    exec_res_t want;
    if (!rst_ni) begin
      result_q.delete();
      branch_target = '0;
      pending_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (result_q.size() == 0) begin
          note_mismatch("result beat with nothing expected", dest_value_i, '0);
        end else begin
          want = result_q.pop_front();
          if (dest_value_i !== want.dest)
            note_mismatch("dest_value", dest_value_i, want.dest);
          if (dest_valid_i !== want.dest_ok)
            note_mismatch("dest_valid", word_t'(dest_valid_i), word_t'(want.dest_ok));
          if (mem_address_i !== want.addr)
            note_mismatch("mem_address", mem_address_i, want.addr);
          if (branch_taken_i !== want.taken)
            note_mismatch("branch_taken", word_t'(branch_taken_i), word_t'(want.taken));
          if (saved_target_out_i !== want.target)
            note_mismatch("saved_target_out", saved_target_out_i, want.target);
          if (divide_fault_i !== want.fault)
            note_mismatch("divide_fault", word_t'(divide_fault_i), word_t'(want.fault));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        want = execute_instr(operation_i,
                             forward_src(rs_route_i, rs_carried_i, rs_file_i,
                                         mem_result_a_i, mem_result_b_i, late_stall_i),
                             forward_src(rt_route_i, rt_carried_i, rt_file_i,
                                         mem_result_a_i, mem_result_b_i, late_stall_i),
                             immediate_i, branch_target);
        branch_target = want.target;
        result_q.push_back(want);
      end
      pending_o = result_q.size();
    end
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
  import peab_pkg::*;

  localparam logic [OpW-1:0] OpUndefLo = 4'd12;
  localparam logic [OpW-1:0] OpUndefHi = 4'd15;
  localparam word_t WordMin = 32'h8000_0000;
  localparam word_t WordMax = 32'h7fff_ffff;
  localparam int LongHoldCycles = 300;
  localparam int WatchdogLimit = 2000;
  localparam int LatencyTail = 60;
  localparam int BlockLen = 100;
  localparam int NumBlocks = 12;

  typedef struct {
    logic [OpW-1:0] op;
    word_t          rs_c;
    word_t          rs_f;
    route_e         rs_r;
    word_t          rt_c;
    word_t          rt_f;
    route_e         rt_r;
    word_t          imm;
    word_t          ma;
    word_t          mb;
    logic           late;
  } instr_t;

  logic           clk = 1'b0;
  logic           rst_n = 1'b1;
  logic           in_valid = 1'b0;
  logic           in_stall;
  logic [OpW-1:0] operation = '0;
  word_t          rs_carried = '0;
  word_t          rs_file = '0;
  route_e         rs_route = ROUTE_CARRIED;
  word_t          rt_carried = '0;
  word_t          rt_file = '0;
  route_e         rt_route = ROUTE_CARRIED;
  word_t          immediate = '0;
  word_t          mem_result_a = '0;
  word_t          mem_result_b = '0;
  logic           late_stall = 1'b0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  word_t          dest_value;
  logic           dest_valid;
  word_t          mem_address;
  logic           branch_taken;
  word_t          saved_target_out;
  logic           divide_fault;

  int   fail_count;
  int   pending;
  int   tx_idle_pct = 30;
  int   rx_idle_pct = 30;
  logic long_hold = 1'b0;
  int   quiet_cycles = 0;

  always #2 clk = ~clk;

  pipeline_execute_alu_branch_top dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .operation_i        (operation),
    .rs_carried_i       (rs_carried),
    .rs_file_i          (rs_file),
    .rs_route_i         (rs_route),
    .rt_carried_i       (rt_carried),
    .rt_file_i          (rt_file),
    .rt_route_i         (rt_route),
    .immediate_i        (immediate),
    .mem_result_a_i     (mem_result_a),
    .mem_result_b_i     (mem_result_b),
    .late_stall_i       (late_stall),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .dest_value_o       (dest_value),
    .dest_valid_o       (dest_valid),
    .mem_address_o      (mem_address),
    .branch_taken_o     (branch_taken),
    .saved_target_out_o (saved_target_out),
    .divide_fault_o     (divide_fault)
  );

  execute_checker u_checker (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_stall_i         (in_stall),
    .operation_i        (operation),
    .rs_carried_i       (rs_carried),
    .rs_file_i          (rs_file),
    .rs_route_i         (rs_route),
    .rt_carried_i       (rt_carried),
    .rt_file_i          (rt_file),
    .rt_route_i         (rt_route),
    .immediate_i        (immediate),
    .mem_result_a_i     (mem_result_a),
    .mem_result_b_i     (mem_result_b),
    .late_stall_i       (late_stall),
    .out_valid_i        (out_valid),
    .out_stall_i        (out_stall),
    .dest_value_i       (dest_value),
    .dest_valid_i       (dest_valid),
    .mem_address_i      (mem_address),
    .branch_taken_i     (branch_taken),
    .saved_target_out_i (saved_target_out),
    .divide_fault_i     (divide_fault),
    .fail_count_o       (fail_count),
    .pending_o          (pending)
  );

  function automatic word_t rand_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 32'd1;
      2: return '1;
      3: return WordMin;
      4: return WordMax;
      5: return $urandom_range(0, 31) - 16;
      default: return $urandom();
    endcase
  endfunction

  function automatic instr_t rand_instr();
    instr_t x;
    word_t  v;
    if ($urandom_range(0, 15) == 0) x.op = OpUndefLo + OpW'($urandom_range(0, 3));
    else x.op = OpW'($urandom_range(int'(OP_NOP), int'(OP_J)));
    x.rs_c = rand_word();
    x.rs_f = rand_word();
    x.rs_r = route_e'($urandom_range(0, 3));
    x.rt_c = rand_word();
    x.rt_f = rand_word();
    x.rt_r = route_e'($urandom_range(0, 3));
    x.imm = rand_word();
    x.ma = rand_word();
    x.mb = rand_word();
    x.late = 1'($urandom_range(0, 1));
    case (x.op)
      OP_DIV: begin
        case ($urandom_range(0, 5))
          0: begin
            // every rt source zero, so any route divides by zero
            x.rt_c = '0;
            x.rt_f = '0;
            x.ma = '0;
            x.mb = '0;
          end
          1: begin
            x.rs_c = WordMin;
            x.rs_f = WordMin;
            x.rt_c = '1;
            x.rt_f = '1;
            x.rs_r = route_e'($urandom_range(0, 1));
            x.rt_r = route_e'($urandom_range(0, 1));
          end
          default: ;
        endcase
      end
      OP_BEQ: begin
        if ($urandom_range(0, 1) == 1) begin
          v = rand_word();
          x.rs_c = v;
          x.rs_f = v;
          x.rt_c = v;
          x.rt_f = v;
          x.ma = v;
          x.mb = v;
        end
      end
      OP_BGEZ, OP_BLEZ: begin
        if ($urandom_range(0, 3) == 0) begin
          x.rs_c = '0;
          x.rs_f = '0;
          x.ma = '0;
          x.mb = '0;
        end
      end
      default: ;
    endcase
    return x;
  endfunction

  function automatic instr_t plain(logic [OpW-1:0] op, word_t rs, word_t rt, word_t imm);
    instr_t x;
    x = rand_instr();
    x.op = op;
    x.rs_c = rs;
    x.rt_c = rt;
    x.imm = imm;
    x.rs_r = ROUTE_CARRIED;
    x.rt_r = ROUTE_CARRIED;
    x.late = 1'b0;
    return x;
  endfunction

  function automatic instr_t routed(route_e rsr, route_e rtr, logic late);
    instr_t x;
    x = plain(OP_ADD, $urandom(), $urandom(), '0);
    x.rs_r = rsr;
    x.rt_r = rtr;
    x.late = late;
    return x;
  endfunction

  // entered right after a falling edge, leaves right after one
  task automatic issue(input instr_t x);
    int gap;
    if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    operation <= x.op;
    rs_carried <= x.rs_c;
    rs_file <= x.rs_f;
    rs_route <= x.rs_r;
    rt_carried <= x.rt_c;
    rt_file <= x.rt_f;
    rt_route <= x.rt_r;
    immediate <= x.imm;
    mem_result_a <= x.ma;
    mem_result_b <= x.mb;
    late_stall <= x.late;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  initial begin : rx_side
    int n;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        long_hold = 1'b0;
        out_stall <= 1'b1;
        repeat (LongHoldCycles) @(negedge clk);
        out_stall <= 1'b0;
      end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
        n = $urandom_range(1, 6);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst_n <= 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    issue(plain(OP_ADD, WordMax, 32'd1, '0));
    issue(plain(OP_SUB, WordMin, 32'd1, '0));
    issue(plain(OP_MUL, WordMax, WordMax, '0));
    issue(plain(OP_MUL, WordMin, '1, '0));
    issue(plain(OP_DIV, -32'd7, 32'd2, '0));
    issue(plain(OP_DIV, 32'd7, -32'd2, '0));
    issue(plain(OP_DIV, 32'd5, '0, '0));
    issue(plain(OP_DIV, WordMin, '1, '0));
    issue(plain(OP_ADDI, WordMax, '0, 32'd1));
    issue(plain(OP_LW, 32'd100, '0, -32'd4));
    issue(plain(OP_SW, WordMin, '0, '1));
    issue(plain(OP_BGEZ, '0, '0, 32'h1000));
    issue(plain(OP_BGEZ, WordMin, '0, 32'h2000));
    issue(plain(OP_BLEZ, '0, '0, 32'h3000));
    issue(plain(OP_BLEZ, 32'd5, '0, 32'h3800));
    issue(plain(OP_BLEZ, '1, '0, WordMin));
    issue(plain(OP_BEQ, 32'd9, 32'd9, 32'h4000));
    issue(plain(OP_BEQ, 32'd9, 32'd8, 32'h5000));
    issue(plain(OP_J, '0, '0, WordMax));
    issue(plain(OP_NOP, 32'd1, 32'd2, 32'd3));
    issue(plain(OpUndefHi, '1, '1, '1));
    issue(routed(ROUTE_MEM_A, ROUTE_MEM_B, 1'b0));
    issue(routed(ROUTE_MEM_B, ROUTE_MEM_A, 1'b1));
    issue(routed(ROUTE_FILE, ROUTE_MEM_A, 1'b0));
    issue(routed(ROUTE_MEM_A, ROUTE_CARRIED, 1'b1));
    drain();

    for (int blk = 0; blk < NumBlocks; blk++) begin
      if (blk >= NumBlocks - 2) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else begin
        tx_idle_pct = $urandom_range(0, 2) * 25;
        rx_idle_pct = $urandom_range(0, 2) * 25;
      end
      if (blk == 3) long_hold = 1'b1;
      if (blk == 6) drain();
      for (int k = 0; k < BlockLen; k++) issue(rand_instr());
    end

    drain();
    repeat (LatencyTail) @(negedge clk);
    if (fail_count == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

endmodule

@@ pipeline_execute_alu_branch_top.f @@
+incdir+src
src/peab_pkg.sv
src/pipeline_execute_alu_branch_top.sv
tb/execute_checker.sv
tb/tb_top.sv
